FILE: rtl/dfe_pkg.sv
// shared types and constants for the delimited field extractor
`timescale 1ns / 1ps
`default_nettype none

package dfe_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_START_PATTERN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_LENGTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_PATTERN   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_LENGTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEST_SIZE     = 3'd4;

  localparam int CfgDataW = 64;

  // output queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // output word packing
  localparam int OutDataW = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_START = 2'd1,
    ST_NO_END   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] start_pattern;
    logic [3:0]  start_length;
    logic [63:0] end_pattern;
    logic [3:0]  end_length;
    logic [15:0] dest_size;
  } dfe_cfg_t;

  typedef struct packed {
    logic        is_final;
    logic [15:0] content_count;
    status_e     status;
    logic [7:0]  out_byte;
  } dfe_item_t;

  typedef struct packed {
    logic      content_valid;
    dfe_item_t content;
    logic      status_valid;
    dfe_item_t status_item;
  } dfe_result_t;

endpackage

`default_nettype wire

FILE: rtl/dfe_core.sv
// marker search, content capture and status generation for one byte per cycle while accept_i is high
`timescale 1ns / 1ps
`default_nettype none

module dfe_core import dfe_pkg::*; #(
  parameter int MAX_MARKER_BYTES = 8,
  parameter int COUNT_BITS       = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  dfe_cfg_t    cfg_i,
  input  wire         accept_i,
  input  wire  [7:0]  byte_i,
  input  wire         last_i,
  output dfe_result_t res_o
);

  localparam int WinW = 8 * MAX_MARKER_BYTES;
  localparam int LenW = $clog2(MAX_MARKER_BYTES + 1);
  localparam int CapW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [CapW-1:0] CntMax = CapW'({COUNT_BITS{1'b1}});

  typedef enum logic [1:0] {
    PH_SEARCH   = 2'd0,
    PH_CONTENT  = 2'd1,
    PH_ENDFOUND = 2'd2
  } phase_e;

  logic [WinW-1:0]       sw_q, sw_d, ew_q, ew_d;
  logic [LenW-1:0]       fill_q, fill_d;
  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  fbz_q, fbz_d;

  logic [LenW-1:0]       ls, le;
  logic                  no_markers;
  logic [CapW-1:0]       cap_w, cap_m;
  logic [COUNT_BITS-1:0] cap;
  logic                  emit_req;
  logic [7:0]            emit_byte;
  logic                  emit_ok;
  status_e               st;

  function automatic logic [WinW-1:0] push_win(input logic [WinW-1:0] win,
                                               input logic [LenW-1:0] len,
                                               input logic [7:0] b);
    logic [WinW-1:0] res;
    res = win >> 8;
    for (int j = 0; j < MAX_MARKER_BYTES; j++) begin
      if (len == LenW'(j + 1)) begin
        res[8*j +: 8] = res[8*j +: 8] | b;
      end
    end
    return res;
  endfunction

  function automatic logic win_match(input logic [WinW-1:0] win,
                                     input logic [WinW-1:0] pat,
                                     input logic [LenW-1:0] len);
    logic m;
    m = 1'b1;
    for (int j = 0; j < MAX_MARKER_BYTES; j++) begin
      if (LenW'(j) < len && win[8*j +: 8] != pat[8*j +: 8]) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  // effective marker lengths, clipped to the window size
  assign ls = (cfg_i.start_length > 4'(MAX_MARKER_BYTES)) ?
              LenW'(MAX_MARKER_BYTES) : LenW'(cfg_i.start_length);
  assign le = (cfg_i.end_length > 4'(MAX_MARKER_BYTES)) ?
              LenW'(MAX_MARKER_BYTES) : LenW'(cfg_i.end_length);
  assign no_markers = (ls == '0) && (le == '0);

  // content cap: dest_size minus one, limited by the counter range
  assign cap_w = (cfg_i.dest_size == 16'd0) ? '0 :
                 CapW'(cfg_i.dest_size) - CapW'(1);
  assign cap_m = (cap_w < CntMax) ? cap_w : CntMax;
  assign cap   = COUNT_BITS'(cap_m);

  always_comb begin
    sw_d      = sw_q;
    ew_d      = ew_q;
    fill_d    = fill_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    fbz_d     = fbz_q;
    emit_req  = 1'b0;
    emit_byte = byte_i;
    emit_ok   = 1'b0;
    st        = ST_OK;
    res_o     = '0;

    if (!no_markers) begin
      if (phase_d == PH_SEARCH && ls == '0) begin
        phase_d = PH_CONTENT;
        fill_d  = '0;
        ew_d    = '0;
      end
      case (phase_d)
        PH_SEARCH: begin
          sw_d = push_win(sw_d, ls, byte_i);
          if (fill_d < ls) begin
            fill_d = fill_d + LenW'(1);
          end
          if (fill_d >= ls &&
              win_match(sw_d, cfg_i.start_pattern[WinW-1:0], ls)) begin
            phase_d = PH_CONTENT;
            fill_d  = '0;
            ew_d    = '0;
          end
        end
        PH_CONTENT: begin
          if (le == '0) begin
            emit_req  = 1'b1;
            emit_byte = byte_i;
          end else begin
            if (fill_d >= le) begin
              emit_req  = 1'b1;
              emit_byte = ew_d[7:0];
            end else begin
              fill_d = fill_d + LenW'(1);
            end
            ew_d = push_win(ew_d, le, byte_i);
            if (fill_d >= le &&
                win_match(ew_d, cfg_i.end_pattern[WinW-1:0], le)) begin
              phase_d = PH_ENDFOUND;
            end
          end
        end
        default: begin
        end
      endcase
    end

    emit_ok = emit_req && (cnt_d < cap);
    if (emit_ok) begin
      if (cnt_d == '0 && emit_byte == 8'h00) begin
        fbz_d = 1'b1;
      end
      cnt_d = cnt_d + COUNT_BITS'(1);
    end

    if (no_markers) begin
      st = ST_EMPTY;
    end else if (phase_d == PH_SEARCH) begin
      st = ST_NO_START;
    end else if (phase_d == PH_CONTENT && le != '0) begin
      st = ST_NO_END;
    end else if (cnt_d == '0 || fbz_d) begin
      st = ST_EMPTY;
    end else begin
      st = ST_OK;
    end

    res_o.content_valid               = emit_ok;
    res_o.content.out_byte            = emit_byte;
    res_o.content.status              = ST_OK;
    res_o.content.content_count       = '0;
    res_o.content.is_final            = 1'b0;
    res_o.status_valid                = last_i;
    res_o.status_item.out_byte        = 8'h00;
    res_o.status_item.status          = st;
    res_o.status_item.content_count   = (st == ST_OK) ? 16'(cnt_d) : 16'd0;
    res_o.status_item.is_final        = 1'b1;

    // run closes on the last source byte
    if (last_i) begin
      sw_d    = '0;
      ew_d    = '0;
      fill_d  = '0;
      phase_d = PH_SEARCH;
      cnt_d   = '0;
      fbz_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= '0;
      ew_q    <= '0;
      fill_q  <= '0;
      phase_q <= PH_SEARCH;
      cnt_q   <= '0;
      fbz_q   <= 1'b0;
    end else if (accept_i) begin
      sw_q    <= sw_d;
      ew_q    <= ew_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fbz_q   <= fbz_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dfe_outq.sv
// small result queue taking up to two words per cycle and giving one
`timescale 1ns / 1ps
`default_nettype none

module dfe_outq import dfe_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  dfe_result_t res_i,
  output logic        space_o,
  output logic        valid_o,
  input  wire         pop_i,
  output dfe_item_t   item_o
);

  dfe_item_t         mem_q [QDepth];
  logic [QPtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              wr_a, wr_b, rd;
  logic [QPtrW-1:0]  wp_b;
  logic [QCntW-1:0]  n_push;

  assign wr_a    = push_i && res_i.content_valid;
  assign wr_b    = push_i && res_i.status_valid;
  assign wp_b    = wr_a ? wp_q + QPtrW'(1) : wp_q;
  assign n_push  = QCntW'(wr_a) + QCntW'(wr_b);
  assign valid_o = (cnt_q != '0);
  assign rd      = valid_o && pop_i;
  assign space_o = (cnt_q <= QCntW'(QDepth - 2));
  assign item_o  = mem_q[rp_q];

  assign wp_d  = wp_q + n_push[QPtrW-1:0];
  assign rp_d  = rd ? rp_q + QPtrW'(1) : rp_q;
  assign cnt_d = cnt_q + n_push - QCntW'(rd);

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_q[wp_q] <= res_i.content;
    end
    if (wr_b) begin
      mem_q[wp_b] <= res_i.status_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/delimited_field_extractor.sv
// top level: config registers, extractor core and result queue
// a result word is formed combinationally in the core and written into the result queue when its byte is taken
// throughput: one byte per cycle while the result queue has space; the window compare in the core is combinational
// a final byte that also releases a content byte yields two words, drained one per cycle while m_axis_tready is high
// the four-word result queue keeps input accepted while up to two results wait
// reset clears config registers, run state and queue at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module delimited_field_extractor import dfe_pkg::*; #(
  parameter int MAX_MARKER_BYTES = 8,
  parameter int COUNT_BITS       = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [7:0]           s_axis_tdata,  // in_byte
  input  wire                  s_axis_tlast,  // source_last
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,  // out_byte, status, content_count, zero pad
  output logic                 m_axis_tlast,  // is_final
  input  wire                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]   cfg_idx_i,
  input  wire  [CfgDataW-1:0]  cfg_data_i
);

  dfe_cfg_t    cfg_q;
  dfe_result_t res;
  dfe_item_t   item;
  logic        accept;
  logic        space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_PATTERN: cfg_q.start_pattern <= cfg_data_i;
        CFG_START_LENGTH:  cfg_q.start_length  <= cfg_data_i[3:0];
        CFG_END_PATTERN:   cfg_q.end_pattern   <= cfg_data_i;
        CFG_END_LENGTH:    cfg_q.end_length    <= cfg_data_i[3:0];
        CFG_DEST_SIZE:     cfg_q.dest_size     <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  dfe_core #(
    .MAX_MARKER_BYTES(MAX_MARKER_BYTES),
    .COUNT_BITS      (COUNT_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .res_o   (res)
  );

  dfe_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .res_i  (res),
    .space_o(space),
    .valid_o(m_axis_tvalid),
    .pop_i  (m_axis_tready),
    .item_o (item)
  );

  assign m_axis_tdata = {6'b0, item.content_count, item.status, item.out_byte};
  assign m_axis_tlast = item.is_final;

endmodule

`default_nettype wire

FILE: tb/delimited_field_extractor_test.sv
// self-checking stream testbench for the delimited field extractor with its own predictor
`timescale 1ns / 1ps

module delimited_field_extractor_test;
  import dfe_pkg::*;

  localparam int MarkerMax  = 8;
  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 1650;

  typedef enum logic [1:0] {
    SEEK_START = 2'd0,
    IN_CONTENT = 2'd1,
    END_SEEN   = 2'd2
  } run_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire                 s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  wire                 m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  wire  [OutDataW-1:0] m_axis_tdata;
  wire                 m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // register mirror and run state of the predictor
  dfe_cfg_t    cfg_mirror = '0;
  logic [63:0] start_win = '0;
  logic [63:0] end_win = '0;
  int unsigned win_fill = 0;
  run_phase_e  run_phase = SEEK_START;
  int unsigned passed_count = 0;
  logic        zero_lead = 1'b0;

  src_byte_t pending_bytes[$];
  dfe_item_t expected_words[$];

  int  mismatches = 0;
  int  item_total = 0;
  int  cycles = 0;
  int  content_seen = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  int  settings_used = 1;
  bit  steady = 1'b0;
  bit  narrow = 1'b0;
  logic [7:0] alpha[3];

  delimited_field_extractor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned clip_len(input logic [3:0] n);
    return (n > MarkerMax) ? MarkerMax : int'(n);
  endfunction

  function automatic logic [63:0] lane_mask(input int unsigned n);
    if (n == 0) return 64'd0;
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [63:0] shift_in(input logic [63:0] w, input int unsigned n,
                                           input logic [7:0] b);
    return (w >> 8) | ({56'd0, b} << (8 * (n - 1)));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic pass_content(input logic [7:0] b);
    dfe_item_t w;
    int unsigned cap;
    cap = (cfg_mirror.dest_size == 0) ? 0 : cfg_mirror.dest_size - 1;
    if (passed_count >= cap) return;
    if (passed_count == 0 && b == 8'd0) zero_lead = 1'b1;
    passed_count++;
    w = '0;
    w.out_byte = b;
    w.status = ST_OK;
    expected_words.push_back(w);
  endtask

  task automatic predict_extraction(input logic [7:0] b, input logic last);
    int unsigned ls;
    int unsigned le;
    dfe_item_t w;
    ls = clip_len(cfg_mirror.start_length);
    le = clip_len(cfg_mirror.end_length);
    if (ls != 0 || le != 0) begin
      if (run_phase == SEEK_START && ls == 0) begin
        run_phase = IN_CONTENT;
        win_fill = 0;
        end_win = '0;
      end
      if (run_phase == SEEK_START) begin
        start_win = shift_in(start_win, ls, b);
        if (win_fill < ls) win_fill++;
        if (win_fill >= ls && ((start_win ^ cfg_mirror.start_pattern) & lane_mask(ls)) == 0)
        begin
          run_phase = IN_CONTENT;
          win_fill = 0;
          end_win = '0;
        end
      end else if (run_phase == IN_CONTENT) begin
        if (le == 0) begin
          pass_content(b);
        end else begin
          if (win_fill >= le) pass_content(end_win[7:0]);
          else win_fill++;
          end_win = shift_in(end_win, le, b);
          if (win_fill >= le && ((end_win ^ cfg_mirror.end_pattern) & lane_mask(le)) == 0)
            run_phase = END_SEEN;
        end
      end
    end
    if (last) begin
      w = '0;
      w.is_final = 1'b1;
      if (ls == 0 && le == 0) w.status = ST_EMPTY;
      else if (run_phase == SEEK_START) w.status = ST_NO_START;
      else if (run_phase == IN_CONTENT && le != 0) w.status = ST_NO_END;
      else if (passed_count == 0 || zero_lead) w.status = ST_EMPTY;
      else w.status = ST_OK;
      if (w.status == ST_OK) w.content_count = passed_count[15:0];
      expected_words.push_back(w);
      start_win = '0;
      end_win = '0;
      win_fill = 0;
      run_phase = SEEK_START;
      passed_count = 0;
      zero_lead = 1'b0;
    end
  endtask

  // source side
  always @(posedge clk_i) begin : drive_source
    src_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
        nxt = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= nxt.data;
        s_axis_tlast <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin : check_words
    dfe_item_t got;
    dfe_item_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_extraction(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte = m_axis_tdata[7:0];
        got.status = status_e'(m_axis_tdata[9:8]);
        got.content_count = m_axis_tdata[25:10];
        got.is_final = m_axis_tlast;
        if (expected_words.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_words.pop_front();
          if (got.is_final !== want.is_final)
            report_mismatch("is_final", 32'(got.is_final), 32'(want.is_final));
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.content_count !== want.content_count)
            report_mismatch("content_count", 32'(got.content_count),
                            32'(want.content_count));
          if (want.is_final) status_seen[want.status]++;
          else content_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_START_PATTERN: cfg_mirror.start_pattern = val;
      CFG_START_LENGTH:  cfg_mirror.start_length = val[3:0];
      CFG_END_PATTERN:   cfg_mirror.end_pattern = val;
      CFG_END_LENGTH:    cfg_mirror.end_length = val[3:0];
      CFG_DEST_SIZE:     cfg_mirror.dest_size = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    src_byte_t e;
    e.data = b;
    e.last = last;
    pending_bytes.push_back(e);
    item_total++;
  endtask

  // block is idle once everything sent has been answered
  task automatic settle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_words.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    if (narrow && $urandom_range(99) < 75) return alpha[$urandom_range(2)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] make_pattern();
    logic [63:0] p;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    p = {$urandom, $urandom};
    if (narrow)
      for (int i = 0; i < 8; i++) p[8*i +: 8] = alpha[$urandom_range(2)];
    return p;
  endfunction

  function automatic logic [63:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 64'd0;
    if (r < 65) return 64'($urandom_range(1, 3));
    if (r < 90) return 64'($urandom_range(4, 8));
    return 64'($urandom_range(9, 15));
  endfunction

  function automatic logic [63:0] pick_dest();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 64'($urandom_range(2, 12));
    if (r < 75) return 64'($urandom_range(1));
    if (r < 90) return 64'($urandom_range(13, 40));
    if (r < 95) return 64'd65535;
    return 64'($urandom_range(65535));
  endfunction

  task automatic pick_config();
    narrow = ($urandom_range(99) < 50);
    for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
    write_reg(CFG_START_PATTERN, make_pattern());
    write_reg(CFG_START_LENGTH, pick_len());
    write_reg(CFG_END_PATTERN, make_pattern());
    write_reg(CFG_END_LENGTH, pick_len());
    write_reg(CFG_DEST_SIZE, pick_dest());
    settings_used++;
  endtask

  // mostly well-formed sources, the rest broken or plain noise
  task automatic queue_source();
    logic [7:0] seq[$];
    int unsigned ls;
    int unsigned le;
    int unsigned kind;
    int unsigned cap;
    int unsigned body;
    int unsigned r;
    ls = clip_len(cfg_mirror.start_length);
    le = clip_len(cfg_mirror.end_length);
    cap = (cfg_mirror.dest_size == 0) ? 0 : cfg_mirror.dest_size - 1;
    kind = $urandom_range(99);
    if (kind >= 93) begin
      repeat ($urandom_range(1, 16)) seq.push_back(pick_byte());
    end else begin
      repeat ($urandom_range(3)) seq.push_back(pick_byte());
      if (kind < 78 || kind >= 85)
        for (int i = 0; i < ls; i++) seq.push_back(cfg_mirror.start_pattern[8*i +: 8]);
      r = $urandom_range(99);
      if (r < 50) body = $urandom_range(4);
      else if (r < 90) body = $urandom_range((cap + 2 < 40) ? cap + 2 : 40);
      else body = $urandom_range(1);
      for (int i = 0; i < body; i++) begin
        if (i == 0 && $urandom_range(99) < 8) seq.push_back(8'd0);
        else seq.push_back(pick_byte());
      end
      if (kind < 70 || kind >= 78)
        for (int i = 0; i < le; i++) seq.push_back(cfg_mirror.end_pattern[8*i +: 8]);
      repeat ($urandom_range(2)) seq.push_back(pick_byte());
      if (kind >= 85 && seq.size() > 1)
        seq = seq[0:$urandom_range(seq.size() - 2)];
    end
    if (seq.size() == 0) seq.push_back(pick_byte());
    foreach (seq[i]) add_byte(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    int phase_no;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no markers at all after reset
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    settle();

    // one-byte markers, upper pattern lanes must be ignored
    write_reg(CFG_START_PATTERN, 64'hFFFF_FFFF_FFFF_FF41);
    write_reg(CFG_START_LENGTH, 64'd1);
    write_reg(CFG_END_PATTERN, 64'h42);
    write_reg(CFG_END_LENGTH, 64'd1);
    write_reg(CFG_DEST_SIZE, 64'd16);
    @(negedge clk_i);
    add_byte(8'h78, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h35, 1'b0);
    add_byte(8'h36, 1'b0); add_byte(8'h42, 1'b0); add_byte(8'h79, 1'b1);
    // start marker missing
    add_byte(8'h7A, 1'b0); add_byte(8'h7A, 1'b1);
    // end marker missing
    add_byte(8'h41, 1'b0); add_byte(8'h31, 1'b0); add_byte(8'h32, 1'b1);
    // empty content and zero first byte
    add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b1);
    add_byte(8'h41, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h42, 1'b1);
    settle();

    // zero capacity
    write_reg(CFG_DEST_SIZE, 64'd0);
    @(negedge clk_i);
    add_byte(8'h41, 1'b0); add_byte(8'h37, 1'b0); add_byte(8'h42, 1'b1);
    settle();

    // end marker dropped in the middle of a run
    write_reg(CFG_DEST_SIZE, 64'd16);
    @(negedge clk_i);
    add_byte(8'h41, 1'b0); add_byte(8'h39, 1'b0);
    settle();
    write_reg(CFG_END_LENGTH, 64'd0);
    @(negedge clk_i);
    add_byte(8'h38, 1'b1);
    settle();

    phase_no = 0;
    while (item_total < ItemTarget + 25) begin
      steady = (phase_no >= 6 && phase_no < 10);
      pick_config();
      @(negedge clk_i);
      repeat ($urandom_range(3, 8)) queue_source();
      settle();
      phase_no++;
    end
    steady = 1'b0;
    repeat (8) @(negedge clk_i);

    if (expected_words.size() != 0)
      report_mismatch("words never delivered", 32'(expected_words.size()), 32'd0);
    $display("sent %0d source bytes under %0d register settings, %0d content words checked",
             item_total, settings_used, content_seen);
    $display("runs closed: ok %0d, no start %0d, no end %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_NO_START], status_seen[ST_NO_END],
             status_seen[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
